// ----- rtl/dtwr_pkg.sv -----
`timescale 1ns / 1ps

package dtwr_pkg;

   localparam int TIMESTAMP_WIDTH = 32;
   localparam int FIELD_W         = 32;
   localparam int RESULT_W        = 32;

   localparam int TW    = TIMESTAMP_WIDTH;
   localparam int EXT_W = (TW > FIELD_W) ? TW : FIELD_W;
   localparam int SUM_W = TW + 2;
   localparam int REM_W = TW + 3;
   localparam int PROD_W = 2 * TW;

   localparam logic STATUS_VALID    = 1'b0;
   localparam logic STATUS_NO_RANGE = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] resp_poll_rx_time;
      logic [FIELD_W-1:0] resp_reply_tx_time;
      logic [FIELD_W-1:0] resp_final_rx_time;
      logic [FIELD_W-1:0] init_poll_tx_time;
      logic [FIELD_W-1:0] init_reply_rx_time;
      logic [FIELD_W-1:0] init_final_tx_time;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0] flight_time;
      logic                result_status;
   } rsp_type;

   typedef struct packed {
      logic              status;
      logic [REM_W-1:0]  rem;
      logic [SUM_W-1:0]  divisor;
      logic [TW-1:0]     num_low;
      logic [TW-1:0]     quot;
   } div_stage_type;

   function automatic logic [TW-1:0] interval(input logic [FIELD_W-1:0] late,
                                              input logic [FIELD_W-1:0] early);
      logic [EXT_W-1:0] diff;
      diff = EXT_W'(late) - EXT_W'(early);
      return diff[TW-1:0];
   endfunction

endpackage

// ----- rtl/dtwr_front.sv -----
`timescale 1ns / 1ps

module dtwr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  dtwr_pkg::req_type       in_data,
   output logic                    out_valid,
   output dtwr_pkg::div_stage_type out_data
);

   logic [dtwr_pkg::TW-1:0] round_a_ff, reply_a_ff, round_b_ff, reply_b_ff;
   logic [dtwr_pkg::TW-1:0] round_a_in, reply_a_in, round_b_in, reply_b_in;
   logic [dtwr_pkg::PROD_W-1:0] prod_a_ff, prod_b_ff, prod_a_in, prod_b_in;
   logic [dtwr_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                        iv_valid_ff, pr_valid_ff, out_valid_ff;
   dtwr_pkg::div_stage_type     out_data_ff, out_data_in;
   logic [dtwr_pkg::PROD_W-1:0] numer;
   logic                        positive;

   always_comb begin
      round_a_in = dtwr_pkg::interval(in_data.init_reply_rx_time, in_data.init_poll_tx_time);
      reply_a_in = dtwr_pkg::interval(in_data.init_final_tx_time, in_data.init_reply_rx_time);
      round_b_in = dtwr_pkg::interval(in_data.resp_final_rx_time, in_data.resp_reply_tx_time);
      reply_b_in = dtwr_pkg::interval(in_data.resp_reply_tx_time, in_data.resp_poll_rx_time);
   end

   always_comb begin
      prod_a_in = dtwr_pkg::PROD_W'(round_a_ff) * dtwr_pkg::PROD_W'(round_b_ff);
      prod_b_in = dtwr_pkg::PROD_W'(reply_a_ff) * dtwr_pkg::PROD_W'(reply_b_ff);
      sum_in    = dtwr_pkg::SUM_W'(round_a_ff) + dtwr_pkg::SUM_W'(round_b_ff)
                + dtwr_pkg::SUM_W'(reply_a_ff) + dtwr_pkg::SUM_W'(reply_b_ff);
   end

   always_comb begin
      positive            = prod_a_ff > prod_b_ff;
      numer               = prod_a_ff - prod_b_ff;
      out_data_in.status  = positive ? dtwr_pkg::STATUS_VALID : dtwr_pkg::STATUS_NO_RANGE;
      out_data_in.rem     = dtwr_pkg::REM_W'(numer[dtwr_pkg::PROD_W-1:dtwr_pkg::TW]);
      out_data_in.divisor = sum_ff;
      out_data_in.num_low = numer[dtwr_pkg::TW-1:0];
      out_data_in.quot    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         iv_valid_ff  <= in_valid;
         pr_valid_ff  <= iv_valid_ff;
         out_valid_ff <= pr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         round_a_ff  <= round_a_in;
         reply_a_ff  <= reply_a_in;
         round_b_ff  <= round_b_in;
         reply_b_ff  <= reply_b_in;
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         sum_ff      <= sum_in;
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- rtl/dtwr_div_cell.sv -----
`timescale 1ns / 1ps

module dtwr_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  dtwr_pkg::div_stage_type in_data,
   output logic                    out_valid,
   output dtwr_pkg::div_stage_type out_data
);

   logic                        out_valid_ff;
   dtwr_pkg::div_stage_type     out_data_ff, out_data_in;
   logic [dtwr_pkg::REM_W-1:0]  shifted;
   logic [dtwr_pkg::REM_W-1:0]  divisor_ext;
   logic                        fits;

   always_comb begin
      shifted     = {in_data.rem[dtwr_pkg::REM_W-2:0], in_data.num_low[dtwr_pkg::TW-1]};
      divisor_ext = dtwr_pkg::REM_W'(in_data.divisor);
      fits        = shifted >= divisor_ext;
      out_data_in         = in_data;
      out_data_in.rem     = fits ? (shifted - divisor_ext) : shifted;
      out_data_in.num_low = {in_data.num_low[dtwr_pkg::TW-2:0], 1'b0};
      out_data_in.quot    = {in_data.quot[dtwr_pkg::TW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ----- rtl/dtwr_divider.sv -----
`timescale 1ns / 1ps

module dtwr_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic                    in_valid,
   input  dtwr_pkg::div_stage_type in_data,
   output logic                    out_valid,
   output dtwr_pkg::div_stage_type out_data
);

   logic                    link_valid [dtwr_pkg::TW+1];
   dtwr_pkg::div_stage_type link_data  [dtwr_pkg::TW+1];

   assign link_valid[0] = in_valid;
   assign link_data[0]  = in_data;

   for (genvar i = 0; i < dtwr_pkg::TW; i++) begin : g_cell
      dtwr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (link_valid[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   assign out_valid = link_valid[dtwr_pkg::TW];
   assign out_data  = link_data[dtwr_pkg::TW];

endmodule

// ----- rtl/ds_twr_time_of_flight.sv -----
// Pipeline: three front stages (intervals, products, difference), one divider cell
// per quotient bit, 32 in all, then the output register. Throughput: one transfer
// per cycle while req_stall is low.
// A skid register behind the output lets one more item drain while a result is stalled.
// Reset clears all valid flags; data registers are not reset.
`timescale 1ns / 1ps

module ds_twr_time_of_flight (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dtwr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dtwr_pkg::rsp_type rsp_data
);

   logic                    enable;
   logic                    front_valid, last_valid;
   dtwr_pkg::div_stage_type front_data, last_data;
   dtwr_pkg::rsp_type       last_rsp;
   logic [dtwr_pkg::RESULT_W-1:0] quot_out;
   logic                    rsp_valid_ff, rsp_valid_in;
   dtwr_pkg::rsp_type       rsp_data_ff, rsp_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   dtwr_pkg::rsp_type       skid_data_ff, skid_data_in;
   logic                    rsp_take;

   assign enable    = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   dtwr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   dtwr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (last_valid),
      .out_data  (last_data)
   );

   if (dtwr_pkg::TW > dtwr_pkg::RESULT_W) begin : g_sat
      assign quot_out = (|last_data.quot[dtwr_pkg::TW-1:dtwr_pkg::RESULT_W]) ?
                        '1 : last_data.quot[dtwr_pkg::RESULT_W-1:0];
   end else begin : g_ext
      assign quot_out = dtwr_pkg::RESULT_W'(last_data.quot);
   end

   always_comb begin
      last_rsp.result_status = last_data.status;
      last_rsp.flight_time   = (last_data.status == dtwr_pkg::STATUS_NO_RANGE) ? '0 : quot_out;
   end

   always_comb begin
      rsp_take      = rsp_valid_ff && !rsp_stall;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (last_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = last_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = last_rsp;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- test/ds_twr_flight_checker.sv -----
`timescale 1ns / 1ps

module ds_twr_flight_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dtwr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dtwr_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                pending
);

   dtwr_pkg::rsp_type expected_flights[$];
   int                error_count = 0;

   assign mismatches = error_count;

   // Exact integer form of the asymmetric estimate, wide enough for timestamps of up to 64 bits.
   function automatic dtwr_pkg::rsp_type predict_flight(input dtwr_pkg::req_type x);
      logic [127:0] mask;
      logic [127:0] round_a;
      logic [127:0] reply_a;
      logic [127:0] round_b;
      logic [127:0] reply_b;
      logic [127:0] prod_round;
      logic [127:0] prod_reply;
      logic [127:0] span;
      logic [127:0] quotient;
      dtwr_pkg::rsp_type r;
      mask       = (128'd1 << dtwr_pkg::TIMESTAMP_WIDTH) - 128'd1;
      round_a    = (128'(x.init_reply_rx_time) - 128'(x.init_poll_tx_time)) & mask;
      reply_a    = (128'(x.init_final_tx_time) - 128'(x.init_reply_rx_time)) & mask;
      round_b    = (128'(x.resp_final_rx_time) - 128'(x.resp_reply_tx_time)) & mask;
      reply_b    = (128'(x.resp_reply_tx_time) - 128'(x.resp_poll_rx_time)) & mask;
      prod_round = round_a * round_b;
      prod_reply = reply_a * reply_b;
      if (prod_round <= prod_reply) begin
         r.flight_time   = '0;
         r.result_status = dtwr_pkg::STATUS_NO_RANGE;
      end else begin
         span     = round_a + round_b + reply_a + reply_b;
         quotient = (prod_round - prod_reply) / span;
         if (quotient > 128'hFFFF_FFFF) begin
            r.flight_time = '1;
         end else begin
            r.flight_time = quotient[dtwr_pkg::RESULT_W-1:0];
         end
         r.result_status = dtwr_pkg::STATUS_VALID;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      dtwr_pkg::rsp_type want;
      if (reset) begin
         expected_flights.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_flights.size() == 0) begin
               $error("result transfer with nothing expected: flight_time %0d result_status %0d",
                      rsp_data.flight_time, rsp_data.result_status);
               error_count++;
            end else begin
               want = expected_flights.pop_front();
               if (rsp_data.flight_time !== want.flight_time) begin
                  $error("flight_time expected %0d got %0d",
                         want.flight_time, rsp_data.flight_time);
                  error_count++;
               end
               if (rsp_data.result_status !== want.result_status) begin
                  $error("result_status expected %0d got %0d",
                         want.result_status, rsp_data.result_status);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_flights.push_back(predict_flight(req_data));
         end
         pending <= expected_flights.size();
      end
   end

endmodule

// ----- test/ds_twr_time_of_flight_tb.sv -----
`timescale 1ns / 1ps

module ds_twr_time_of_flight_tb;

   localparam int RANDOM_EXCHANGES = 1900;
   localparam int CALM_TAIL        = 250;
   localparam int SETTLE_CYCLES    = 40;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   dtwr_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   dtwr_pkg::rsp_type rsp_data;

   int mismatches;
   int pending;
   int traffic_mode = 1;

   ds_twr_time_of_flight dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   ds_twr_flight_checker flight_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever begin
         #6 clock = ~clock;
      end
   end

   // Lays out the six timestamps of one exchange from the two local clocks and four intervals.
   function automatic dtwr_pkg::req_type place_exchange(input logic [31:0] base_a,
                                                        input logic [31:0] base_b,
                                                        input logic [31:0] round_a,
                                                        input logic [31:0] reply_a,
                                                        input logic [31:0] round_b,
                                                        input logic [31:0] reply_b);
      dtwr_pkg::req_type x;
      x.init_poll_tx_time  = base_a;
      x.init_reply_rx_time = base_a + round_a;
      x.init_final_tx_time = base_a + round_a + reply_a;
      x.resp_poll_rx_time  = base_b;
      x.resp_reply_tx_time = base_b + reply_b;
      x.resp_final_rx_time = base_b + reply_b + round_b;
      return x;
   endfunction

   function automatic logic [31:0] random_span();
      case ($urandom_range(0, 3))
         0: begin
            return $urandom_range(0, 255);
         end
         1: begin
            return $urandom_range(0, 1 << 16);
         end
         2: begin
            return $urandom_range(0, 1 << 24);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   function automatic dtwr_pkg::req_type random_exchange();
      logic [31:0]       flight;
      logic [31:0]       reply_a;
      logic [31:0]       reply_b;
      dtwr_pkg::req_type x;
      int                pick;
      pick    = $urandom_range(0, 19);
      flight  = ($urandom_range(0, 3) == 0) ? random_span() : 32'($urandom_range(0, 4000));
      reply_a = random_span();
      reply_b = random_span();
      if (pick < 3) begin
         x.resp_poll_rx_time  = $urandom;
         x.resp_reply_tx_time = $urandom;
         x.resp_final_rx_time = $urandom;
         x.init_poll_tx_time  = $urandom;
         x.init_reply_rx_time = $urandom;
         x.init_final_tx_time = $urandom;
      end else if (pick == 5) begin
         // The final arrives too early for a real flight, so the estimate can turn negative.
         x = place_exchange($urandom, $urandom, reply_b - flight, reply_a,
                            reply_a - flight, reply_b);
      end else begin
         x = place_exchange($urandom, $urandom,
                            reply_b + 2 * flight + 32'($urandom_range(0, 63)), reply_a,
                            reply_a + 2 * flight + 32'($urandom_range(0, 63)), reply_b);
         if (pick < 5) begin
            case ($urandom_range(0, 5))
               0: begin
                  x.resp_poll_rx_time = $urandom;
               end
               1: begin
                  x.resp_reply_tx_time = $urandom;
               end
               2: begin
                  x.resp_final_rx_time = $urandom;
               end
               3: begin
                  x.init_poll_tx_time = $urandom;
               end
               4: begin
                  x.init_reply_rx_time = $urandom;
               end
               default: begin
                  x.init_final_tx_time = $urandom;
               end
            endcase
         end
      end
      return x;
   endfunction

   task automatic send_exchange(input dtwr_pkg::req_type item);
      if (traffic_mode != 0 && $urandom_range(0, (traffic_mode == 1) ? 7 : 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   initial begin
      dtwr_pkg::req_type opening[$];
      opening.push_back('0);
      opening.push_back('1);
      opening.push_back({6{32'hAAAA_5555}});
      opening.push_back({6{32'h5555_AAAA}});
      opening.push_back(place_exchange(32'd1000, 32'd5000, 32'd3200, 32'd4000,
                                       32'd4200, 32'd3000));
      opening.push_back(place_exchange(32'd10, 32'd20, 32'd7, 32'd7, 32'd7, 32'd7));
      opening.push_back(place_exchange(32'd0, 32'd0, 32'd100, 32'd5000, 32'd100, 32'd5000));
      opening.push_back(place_exchange(32'd50, 32'd60, 32'd0, 32'd9, 32'd12345, 32'd3));
      opening.push_back(place_exchange(32'd0, 32'd0, '1, 32'd0, '1, 32'd0));
      opening.push_back(place_exchange(32'd0, 32'd0, '1, 32'd0, 32'd1, 32'd0));
      opening.push_back(place_exchange(32'd0, 32'd0, 32'd1, 32'd0, 32'd1, 32'd0));
      opening.push_back(place_exchange(32'd0, 32'd0, '1, '1, '1, '1));
      opening.push_back(place_exchange(32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h300, 32'h500,
                                       32'h400, 32'h200));
      opening.push_back(place_exchange(32'h1234_5678, 32'h9ABC_DEF0, 32'h8000_0001,
                                       32'h8000_0000, 32'h8000_0001, 32'h8000_0000));
      opening.push_back(place_exchange(32'd7, 32'd9, 32'h3000_0000, 32'h1000_0000,
                                       32'h3000_0000, 32'h1000_0000));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (opening[i]) begin
         send_exchange(opening[i]);
      end
      for (int n = 0; n < RANDOM_EXCHANGES; n++) begin
         if (n >= RANDOM_EXCHANGES - CALM_TAIL) begin
            traffic_mode = 0;
         end else if (n % 128 == 0) begin
            traffic_mode = $urandom_range(0, 2);
         end
         send_exchange(random_exchange());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (traffic_mode != 0 && $urandom_range(0, (traffic_mode == 1) ? 7 : 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
